// File: hw/rtl/usb_config_descriptor_parser_core_macros.svh
// ----------------------------------------------------------------------------
// usb configuration descriptor parser assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef USB_CONFIG_DESCRIPTOR_PARSER_CORE_MACROS_SVH
`define USB_CONFIG_DESCRIPTOR_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define UCDP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent checked in the cycle after the antecedent
`define UCDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define UCDP_ASSERT(lbl, clk, rst_n, prop, msg)
`define UCDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/ucdp_pkg.sv
// ----------------------------------------------------------------------------
// ucdp_pkg
// types and constants shared by the descriptor parser modules
// ----------------------------------------------------------------------------
package ucdp_pkg;

    localparam int BODY_W     = 56;
    localparam int BODY_BYTES = BODY_W / 8;
    localparam int RES_DEPTH  = 4;

    // descriptor type codes
    localparam logic [7:0] DESC_TYPE_CONFIG   = 8'd2;
    localparam logic [7:0] DESC_TYPE_IFACE    = 8'd4;
    localparam logic [7:0] DESC_TYPE_ENDPOINT = 8'd5;

    // required descriptor lengths
    localparam logic [7:0] LEN_CONFIG   = 8'd9;
    localparam logic [7:0] LEN_IFACE    = 8'd9;
    localparam logic [7:0] LEN_ENDPOINT = 8'd7;
    localparam logic [7:0] LEN_MIN      = 8'd2;
    localparam logic [7:0] IFACE_MAX    = 8'd255;

    typedef enum logic [2:0] {
        REC_CONFIG   = 3'd0,
        REC_IFACE    = 3'd1,
        REC_ENDPOINT = 3'd2,
        REC_END_OK   = 3'd3,
        REC_ERROR    = 3'd4
    } t_rec_kind;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_CONFIG_SIZE = 3'd1,
        ERR_IFACE_SIZE  = 3'd2,
        ERR_EP_SIZE     = 3'd3,
        ERR_ORPHAN_EP   = 3'd4,
        ERR_SHORT_LEN   = 3'd5
    } t_err_code;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        t_rec_kind         rec_kind;
        t_err_code         err_code;
        logic [BODY_W-1:0] body;
        logic [7:0]        bad_length;
        logic [7:0]        iface_ordinal;
        logic              final_res;
    } t_out_item;

endpackage

// File: hw/rtl/ucdp_parser.sv
// ----------------------------------------------------------------------------
// ucdp_parser
// per-byte descriptor state update, yields up to two results per byte
// ----------------------------------------------------------------------------
`include "usb_config_descriptor_parser_core_macros.svh"

module ucdp_parser import ucdp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic [1:0] o_count,
    output t_out_item o_res0,
    output t_out_item o_res1
);

    logic [7:0]        r_len, n_len;
    logic [7:0]        r_type, n_type;
    logic [7:0]        r_pos, n_pos;
    logic [BODY_W-1:0] r_buf, n_buf;
    logic [7:0]        r_iface, n_iface;
    logic              r_discard, n_discard;

    logic [7:0]        len_cur;
    logic [7:0]        type_cur;
    logic [BODY_W-1:0] buf_cur;
    logic [7:0]        iface_cur;
    logic              short_len;
    logic              complete;
    logic              rec_ok;
    logic              iface_inc;
    t_rec_kind         kind;
    t_err_code         err;
    t_out_item         rec_res;
    t_out_item         end_res;
    t_out_item         err_res;

    always_comb begin
        len_cur  = (r_pos == 8'd0) ? i_item.data_byte : r_len;
        type_cur = (r_pos == 8'd1) ? i_item.data_byte : r_type;
        buf_cur  = (r_pos == 8'd0) ? '0 : r_buf;
        for (int k = 0; k < BODY_BYTES; k++) begin
            if (r_pos == 8'(k + 2)) begin
                buf_cur[8*k +: 8] = i_item.data_byte;
            end
        end

        short_len = (r_pos != 8'd0) && (len_cur < LEN_MIN);
        complete  = (r_pos != 8'd0) && !short_len && (r_pos == len_cur - 8'd1);

        err       = ERR_NONE;
        rec_ok    = 1'b0;
        kind      = REC_CONFIG;
        iface_inc = 1'b0;
        if (short_len) begin
            err = ERR_SHORT_LEN;
        end else if (complete) begin
            priority if (type_cur == DESC_TYPE_CONFIG) begin
                if (len_cur != LEN_CONFIG) begin
                    err = ERR_CONFIG_SIZE;
                end else begin
                    rec_ok = 1'b1;
                    kind   = REC_CONFIG;
                end
            end else if (type_cur == DESC_TYPE_IFACE) begin
                if (len_cur != LEN_IFACE) begin
                    err = ERR_IFACE_SIZE;
                end else begin
                    rec_ok    = 1'b1;
                    kind      = REC_IFACE;
                    iface_inc = 1'b1;
                end
            end else if (type_cur == DESC_TYPE_ENDPOINT) begin
                if (len_cur != LEN_ENDPOINT) begin
                    err = ERR_EP_SIZE;
                end else if (r_iface == 8'd0) begin
                    err = ERR_ORPHAN_EP;
                end else begin
                    rec_ok = 1'b1;
                    kind   = REC_ENDPOINT;
                end
            end else begin
                // unknown type, record skipped
                rec_ok = 1'b0;
            end
        end

        iface_cur = (iface_inc && (r_iface != IFACE_MAX)) ? r_iface + 8'd1 : r_iface;

        rec_res = '{rec_kind: kind, err_code: ERR_NONE, body: buf_cur,
                    bad_length: 8'd0, iface_ordinal: iface_cur, final_res: 1'b0};
        end_res = '{rec_kind: REC_END_OK, err_code: ERR_NONE, body: '0,
                    bad_length: 8'd0, iface_ordinal: iface_cur, final_res: 1'b1};
        err_res = '{rec_kind: REC_ERROR, err_code: err, body: '0,
                    bad_length: len_cur, iface_ordinal: r_iface, final_res: 1'b1};

        o_res0  = end_res;
        o_res1  = end_res;
        o_count = 2'd0;
        if (i_valid && !r_discard) begin
            if (err != ERR_NONE) begin
                o_res0  = err_res;
                o_count = 2'd1;
            end else if (rec_ok) begin
                o_res0  = rec_res;
                o_count = i_item.frame_end ? 2'd2 : 2'd1;
            end else if (i_item.frame_end) begin
                o_count = 2'd1;
            end
        end

        n_len     = r_len;
        n_type    = r_type;
        n_pos     = r_pos;
        n_buf     = r_buf;
        n_iface   = r_iface;
        n_discard = r_discard;
        if (i_valid) begin
            if (i_item.frame_end) begin
                n_len     = '0;
                n_type    = '0;
                n_pos     = '0;
                n_buf     = '0;
                n_iface   = '0;
                n_discard = 1'b0;
            end else if (!r_discard) begin
                if (err != ERR_NONE) begin
                    n_discard = 1'b1;
                end else begin
                    n_len   = len_cur;
                    n_type  = type_cur;
                    n_buf   = buf_cur;
                    n_iface = iface_cur;
                    n_pos   = complete ? 8'd0 : r_pos + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_type    <= '0;
            r_pos     <= '0;
            r_buf     <= '0;
            r_iface   <= '0;
            r_discard <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_type    <= n_type;
            r_pos     <= n_pos;
            r_buf     <= n_buf;
            r_iface   <= n_iface;
            r_discard <= n_discard;
        end
    end

    `UCDP_ASSERT(a_err_alone_final, i_clk, i_rst_n, (o_count == 2'd0) || (o_res0.rec_kind != REC_ERROR) || (o_res0.final_res && (o_count == 2'd1)), "error result not alone or not final")
    `UCDP_ASSERT(a_discard_silent, i_clk, i_rst_n, !r_discard || (o_count == 2'd0), "result while discarding")
    `UCDP_ASSERT_NEXT(a_frame_clears, i_clk, i_rst_n, i_valid && i_item.frame_end, (r_pos == 8'd0) && (r_iface == 8'd0) && !r_discard, "frame state not cleared")

endmodule

// File: hw/rtl/ucdp_res_fifo.sv
// ----------------------------------------------------------------------------
// ucdp_res_fifo
// small result queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`include "usb_config_descriptor_parser_core_macros.svh"

module ucdp_res_fifo import ucdp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_out_item  i_push0,
    input  t_out_item  i_push1,
    output logic       o_room,
    input  logic       i_pop,
    output logic       o_valid,
    output t_out_item  o_data
);

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    t_out_item          r_mem [RES_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wptr1;
    logic               pop_ok;

    assign wptr1   = r_wptr + PTR_W'(1);
    assign pop_ok  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    // two free entries are needed for a byte that may yield two results
    assign o_room  = (r_count <= CNT_W'(RES_DEPTH - 2));

    always_comb begin
        n_wptr  = r_wptr + PTR_W'(i_push_cnt);
        n_rptr  = pop_ok ? r_rptr + PTR_W'(1) : r_rptr;
        n_count = r_count + CNT_W'(i_push_cnt) - CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wptr1] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    `UCDP_ASSERT(a_no_overflow, i_clk, i_rst_n, r_count <= CNT_W'(RES_DEPTH), "result queue overflow")
    `UCDP_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (r_count != '0) || (r_rptr == r_wptr), "empty queue with unequal pointers")
    `UCDP_ASSERT_NEXT(a_single_push, i_clk, i_rst_n, (i_push_cnt == 2'd1) && !pop_ok, r_count == $past(r_count) + CNT_W'(1), "count did not follow single push")

endmodule

// File: hw/rtl/usb_config_descriptor_parser_core.sv
// ----------------------------------------------------------------------------
// usb_config_descriptor_parser_core
// streaming parser for usb configuration descriptor sets
// ----------------------------------------------------------------------------
// Takes one byte of a configuration descriptor set per transfer and gives
// configuration, interface and endpoint records, an error record on a bad
// length or an endpoint before any interface, and an end-ok record on the
// byte marked frame_end. A byte is accepted every cycle as long as the
// four-entry result queue has two free entries. A byte is parsed in the
// cycle it sits in the input register, and its results are written into the
// queue at the next edge, where they raise output valid. Output runs at one
// result transfer per cycle while i_out_ready is high, so a byte that ends
// both a record and the frame puts two results on the output; sustained rate
// is one byte per cycle when the consumer keeps i_out_ready high.

module usb_config_descriptor_parser_core import ucdp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // byte input channel
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    // result output channel
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // input register
    logic      r_in_valid, n_in_valid;
    t_in_item  r_in_data;

    // parser to queue
    logic [1:0] res_cnt;
    t_out_item  res0;
    t_out_item  res1;
    logic       q_room;
    logic       advance;

    // the held byte moves into the parser only when the queue can take
    // both possible results of it
    assign advance    = r_in_valid && q_room;
    // input register frees up in the same cycle the held byte advances
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // descriptor state and result generation
    ucdp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_item  (r_in_data),
        .o_count (res_cnt),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    // result queue doubles as the output register
    ucdp_res_fifo u_res_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (res_cnt),
        .i_push0    (res0),
        .i_push1    (res1),
        .o_room     (q_room),
        .i_pop      (i_out_ready),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for usb_config_descriptor_parser_core
// drives descriptor-set bytes through the valid/ready input channel, models
// the record parser alongside the block and compares every result transfer
// with the record the model expects, in order
// ----------------------------------------------------------------------------

module testbench;
    import ucdp_pkg::*;

    // quiet cycles (no transfer on either side) before the run is called hung
    localparam int STALL_LIMIT  = 1000;
    // cycles allowed for late results once the expected queue has drained
    localparam int DRAIN_CYCLES = 20;
    // bytes of live (not discarded) random traffic
    localparam int RANDOM_BYTES = 1350;
    localparam int MAX_REPORTS  = 10;

    // ------------------------------------------------------------------------
    // record parser model and expected-record queue
    // ------------------------------------------------------------------------
    class descriptor_record_board;
        t_out_item         expected_q[$];
        int unsigned       fault_count;
        int unsigned       parsed_bytes;
        // current record and frame state
        logic [7:0]        rec_len;
        logic [7:0]        rec_type;
        logic [7:0]        rec_pos;
        logic [BODY_W-1:0] body_acc;
        logic [7:0]        ifaces;
        logic              dropping;

        function new();
            clear_frame();
            fault_count  = 0;
            parsed_bytes = 0;
        endfunction

        function void clear_frame();
            rec_len  = '0;
            rec_type = '0;
            rec_pos  = '0;
            body_acc = '0;
            ifaces   = '0;
            dropping = 1'b0;
        endfunction

        function void queue_record(t_rec_kind kind, t_err_code err,
                                   logic [BODY_W-1:0] body, logic [7:0] bad_len,
                                   logic last);
            t_out_item r;
            r.rec_kind      = kind;
            r.err_code      = err;
            r.body          = body;
            r.bad_length    = bad_len;
            r.iface_ordinal = ifaces;
            r.final_res     = last;
            expected_q = {expected_q, r};
        endfunction

        // one accepted input transfer
        function void take_byte(t_in_item item);
            logic [7:0] pos;
            t_err_code  err;
            logic       done;
            int         shift;
            pos  = rec_pos;
            err  = ERR_NONE;
            done = 1'b0;

            // after an error only frame_end matters, and it gives no record
            if (dropping) begin
                if (item.frame_end)
                    clear_frame();
                return;
            end
            parsed_bytes++;

            if (pos == 8'd0) begin
                rec_len  = item.data_byte;
                body_acc = '0;
            end else if (pos == 8'd1) begin
                rec_type = item.data_byte;
            end else if (pos <= 8'd8) begin
                shift = (int'(pos) - 2) * 8;
                body_acc[shift +: 8] = item.data_byte;
            end

            // a length below 2 can never complete, flagged on the type byte
            if (pos >= 8'd1) begin
                if (rec_len < LEN_MIN)
                    err = ERR_SHORT_LEN;
                else if (pos == rec_len - 8'd1)
                    done = 1'b1;
            end

            if (done) begin
                rec_pos = '0;
                if (rec_type == DESC_TYPE_CONFIG) begin
                    if (rec_len != LEN_CONFIG)
                        err = ERR_CONFIG_SIZE;
                    else
                        queue_record(REC_CONFIG, ERR_NONE, body_acc, '0, 1'b0);
                end else if (rec_type == DESC_TYPE_IFACE) begin
                    if (rec_len != LEN_IFACE) begin
                        err = ERR_IFACE_SIZE;
                    end else begin
                        if (ifaces != IFACE_MAX)
                            ifaces++;
                        queue_record(REC_IFACE, ERR_NONE, body_acc, '0, 1'b0);
                    end
                end else if (rec_type == DESC_TYPE_ENDPOINT) begin
                    if (rec_len != LEN_ENDPOINT)
                        err = ERR_EP_SIZE;
                    else if (ifaces == 8'd0)
                        err = ERR_ORPHAN_EP;
                    else
                        queue_record(REC_ENDPOINT, ERR_NONE, body_acc, '0, 1'b0);
                end
            end else if (err == ERR_NONE) begin
                rec_pos = pos + 8'd1;
            end

            if (err != ERR_NONE) begin
                queue_record(REC_ERROR, err, '0, rec_len, 1'b1);
                if (item.frame_end)
                    clear_frame();
                else
                    dropping = 1'b1;
                return;
            end

            if (item.frame_end) begin
                queue_record(REC_END_OK, ERR_NONE, '0, '0, 1'b1);
                clear_frame();
            end
        endfunction

        function string describe(t_out_item r);
            return $sformatf("kind=%0d err=%0d body=%014h bad_len=%0d iface=%0d final=%0b",
                             r.rec_kind, r.err_code, r.body, r.bad_length,
                             r.iface_ordinal, r.final_res);
        endfunction

        // one accepted output transfer
        function void check_record(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t: unexpected record: got %s", $time, describe(got));
                return;
            end
            want = expected_q.pop_front();
            if (got.rec_kind !== want.rec_kind || got.err_code !== want.err_code ||
                got.body !== want.body || got.bad_length !== want.bad_length ||
                got.iface_ordinal !== want.iface_ordinal ||
                got.final_res !== want.final_res) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t: record mismatch: expected %s, got %s",
                             $time, describe(want), describe(got));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block hookup
    // ------------------------------------------------------------------------
    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    // while set, neither side inserts bubbles
    logic      calm = 1'b0;
    int        quiet_cycles = 0;

    descriptor_record_board board = new();

    // byte image of the frame being built, sent front to back
    logic [7:0] frame_buf[$];

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    usb_config_descriptor_parser_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // result side: check each transfer, then pick ready for the next cycle
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_record(out_data);
        // roughly one stall cycle in ten, none during the calm stretch
        out_ready <= calm || ($urandom_range(99) >= 10);
    end

    // hang detection: any transfer resets the count
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // byte driver and frame builders
    // ------------------------------------------------------------------------

    // one byte transfer, with an optional random bubble ahead of it
    task automatic push_byte(input logic [7:0] b, input logic fe);
        t_in_item item;
        item.data_byte = b;
        item.frame_end = fe;
        while (!calm && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        board.take_byte(item);
    endtask

    // append one byte to the frame image
    task automatic append_byte(input logic [7:0] b);
        frame_buf = {frame_buf, b};
    endtask

    // send the first keep bytes of the frame, frame_end on the last of them
    task automatic send_frame(input int keep);
        for (int i = 0; i < keep; i++)
            push_byte(frame_buf[i], i == keep - 1);
        frame_buf.delete();
    endtask

    // load n bytes from a vector, most significant byte first
    task automatic load_bytes(input logic [71:0] v, input int n);
        for (int i = 0; i < n; i++)
            append_byte(v[8*(n-1-i) +: 8]);
    endtask

    // length byte, type byte, then random bytes up to the length
    task automatic add_record(input logic [7:0] len, input logic [7:0] kind);
        append_byte(len);
        append_byte(kind);
        for (int i = 2; i < int'(len); i++)
            append_byte(8'($urandom_range(255)));
    endtask

    // a type the parser skips
    function automatic logic [7:0] other_type();
        logic [7:0] t;
        do begin
            t = 8'($urandom_range(255));
        end while (t == DESC_TYPE_CONFIG || t == DESC_TYPE_IFACE ||
                   t == DESC_TYPE_ENDPOINT);
        return t;
    endfunction

    // any length but the required one, now and then a very long one
    function automatic logic [7:0] wrong_len(input logic [7:0] good);
        logic [7:0] v;
        do begin
            v = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                         : 8'($urandom_range(20));
        end while (v == good);
        return v;
    endfunction

    // config, then interfaces each with a few endpoints, skipped records mixed in
    task automatic build_good_frame();
        int n_if;
        frame_buf.delete();
        add_record(LEN_CONFIG, DESC_TYPE_CONFIG);
        n_if = $urandom_range(3);
        repeat (n_if) begin
            if ($urandom_range(4) == 0)
                add_record(8'($urandom_range(2, 12)), other_type());
            add_record(LEN_IFACE, DESC_TYPE_IFACE);
            repeat ($urandom_range(3))
                add_record(LEN_ENDPOINT, DESC_TYPE_ENDPOINT);
        end
        if ($urandom_range(3) == 0)
            add_record(8'($urandom_range(2, 12)), other_type());
    endtask

    // a valid prefix, one faulty record, then junk that must be ignored
    task automatic build_broken_frame();
        int fault;
        int n_if;
        frame_buf.delete();
        fault = $urandom_range(4);
        // an orphan endpoint needs a frame with no interface yet
        n_if  = (fault == 4) ? 0 : $urandom_range(2);
        if ($urandom_range(1))
            add_record(LEN_CONFIG, DESC_TYPE_CONFIG);
        repeat (n_if) begin
            add_record(LEN_IFACE, DESC_TYPE_IFACE);
            if ($urandom_range(1))
                add_record(LEN_ENDPOINT, DESC_TYPE_ENDPOINT);
        end
        case (fault)
            0: add_record(wrong_len(LEN_CONFIG), DESC_TYPE_CONFIG);
            1: add_record(wrong_len(LEN_IFACE), DESC_TYPE_IFACE);
            2: add_record(wrong_len(LEN_ENDPOINT), DESC_TYPE_ENDPOINT);
            3: add_record(8'($urandom_range(1)), 8'($urandom_range(255)));
            default: add_record(LEN_ENDPOINT, DESC_TYPE_ENDPOINT);
        endcase
        repeat ($urandom_range(6))
            append_byte(8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned base;
        int          pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // config record ending on the frame_end byte: config then end ok
        load_bytes({8'd9, DESC_TYPE_CONFIG, 56'h55_fe_7f_80_01_ff_00}, 9);
        send_frame(9);
        // short length, error lands on the frame_end byte
        load_bytes(72'({8'd1, DESC_TYPE_CONFIG}), 2);
        send_frame(2);
        // zero length, error on the type byte, then a frame_end that must be ignored
        load_bytes(72'({8'd0, 8'hff, 8'h12}), 3);
        send_frame(3);
        // config record of wrong length, trailing byte dropped
        load_bytes(72'({8'd3, DESC_TYPE_CONFIG, 8'h00, 8'h07}), 4);
        send_frame(4);
        // interface cut short by frame_end: partial record dropped, end ok
        load_bytes(72'({8'd9, DESC_TYPE_IFACE, 8'h01}), 3);
        send_frame(3);
        // minimal skipped record ending on frame_end
        load_bytes(72'({8'd2, 8'h21}), 2);
        send_frame(2);

        // random frames, mostly well formed
        base = board.parsed_bytes;
        while (board.parsed_bytes - base < RANDOM_BYTES) begin
            calm = (board.parsed_bytes - base >= 500) && (board.parsed_bytes - base < 800);
            pick = $urandom_range(99);
            if (pick < 70) begin
                build_good_frame();
                send_frame(frame_buf.size());
            end else if (pick < 80) begin
                // truncated somewhere inside the frame
                build_good_frame();
                send_frame($urandom_range(1, frame_buf.size() - 1));
            end else if (pick < 90) begin
                build_broken_frame();
                send_frame(frame_buf.size());
            end else if (pick < 96) begin
                // raw noise
                repeat ($urandom_range(1, 24))
                    append_byte(8'($urandom_range(255)));
                send_frame(frame_buf.size());
            end else begin
                // skipped records at the length extremes
                add_record(8'd255, other_type());
                add_record(LEN_MIN, other_type());
                send_frame(frame_buf.size());
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        // catch any stray result behind the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.fault_count == 0 && board.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ucdp_pkg.sv
hw/rtl/ucdp_parser.sv
hw/rtl/ucdp_res_fifo.sv
hw/rtl/usb_config_descriptor_parser_core.sv
bench/testbench.sv
